### src/fsk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fsk_pkg
// Shared types and constants for the framed FSK modulator: field widths,
// frame length, register codes and register reset values.
// ---------------------------------------------------------------------------
package fsk_pkg;

    // table and frame geometry
    localparam int TABLE_SIZE_DEF = 35;
    localparam int FRAME_LEN      = 11;
    localparam int IDX_W          = 6;
    localparam int ROM_DEPTH      = 64;

    // field and state widths
    localparam int SAMPLE_W = 12;
    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 14;
    localparam int PTR_W    = 4;
    localparam int CNT_W    = 6;
    localparam int STEP_W   = 11;
    localparam int SPAN_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // register reset values
    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 11'd468;
    localparam logic [SPAN_W-1:0] FIRST_SPAN_RST = 6'd19;
    localparam logic [SPAN_W-1:0] LAST_SPAN_RST  = 6'd15;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_FIRST_SPAN = 2'd1,
        CFG_LAST_SPAN  = 2'd2
    } t_cfg_idx;

    // input word kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

endpackage
`default_nettype wire

### src/fsk_sine_rom.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fsk_sine_rom
// Constant sine table, 2048*(1+sin) in 12 bits. Entries are worked out at
// elaboration with a fixed-point Taylor series in Q30; entries past the
// table size read as zero.
// ---------------------------------------------------------------------------
module fsk_sine_rom #(
    parameter int TABLE_SIZE = fsk_pkg::TABLE_SIZE_DEF
) (
    input  wire logic [fsk_pkg::IDX_W-1:0]    i_index,
    output logic      [fsk_pkg::SAMPLE_W-1:0] o_sample
);

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] HALF_PI   = PI_Q30 >> 1;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    logic [fsk_pkg::SAMPLE_W-1:0] w_rom [fsk_pkg::ROM_DEPTH];

    // one constant per entry
    for (genvar gi = 0; gi < fsk_pkg::ROM_DEPTH; gi++) begin : g_entry
        localparam logic [63:0] XA = ((64'd6283184 * 64'(gi)) << 30) /
                                     (64'd1000000 * 64'(TABLE_SIZE));
        localparam bit          NEG = (XA >= PI_Q30);
        localparam logic [63:0] XB  = NEG ? (XA - PI_Q30) : XA;
        localparam logic [63:0] XC  = (XB > HALF_PI) ? (PI_Q30 - XB) : XB;
        localparam logic [63:0] X2  = (XC * XC) >> 30;
        localparam logic [63:0] T1  = ((XC * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
        localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
        localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd272;
        localparam logic signed [63:0] SUM = $signed(XC) - $signed(T1) + $signed(T2)
                                           - $signed(T3) + $signed(T4) - $signed(T5)
                                           + $signed(T6) - $signed(T7) + $signed(T8);
        localparam logic signed [63:0] SSUM = NEG ? -SUM : SUM;
        localparam logic signed [63:0] VAL  = 64'sd2048 * ONE_Q30 + 64'sd2048 * SSUM;
        localparam logic signed [63:0] VSH  = VAL >>> 30;
        localparam logic [fsk_pkg::SAMPLE_W-1:0] ENTRY =
            (VAL < 64'sd0)     ? 12'd0 :
            (VSH > 64'sd4095)  ? 12'd4095 : VSH[fsk_pkg::SAMPLE_W-1:0];

        assign w_rom[gi] = (gi < TABLE_SIZE) ? ENTRY : '0;
    end

    // table lookup
    assign o_sample = w_rom[i_index];

endmodule
`default_nettype wire

### src/fsk_uart_frame_modulator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fsk_uart_frame_modulator
// Framed FSK modulator: loads a character, sends it as an 11-bit frame
// (start, eight data bits MSB first, odd parity over bits 0..6, stop), one
// 12-bit sine sample per tick word.
// ---------------------------------------------------------------------------
// Usage
//   Slave channel: tuser selects the word kind (0 tick, 1 load), tdata holds
//   the character for a load. A load returns nothing; a tick returns one
//   sample word on the master channel, with tlast high on the tick that ends
//   the stop bit.
//   An accepted tick's sample reaches the master side in the next cycle.
//   Unstalled, one word is taken per cycle: the state update and the table
//   lookup sit between the state registers and the output register, and
//   a full output register is refilled in the same cycle it is drained.
//   A stalled master side holds the output register; the slave side then
//   stays not ready until the pending sample is taken.
//   Mark bits and the idle line step the table by one entry per tick and
//   last TABLE_SIZE ticks; space bits step a Q8 accumulator by phase_step
//   and last space_first_span + space_last_span ticks.
//   Reset (synchronous, active low) idles the line, clears the counters
//   and loads the register defaults; the table needs no fill time.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the
//   user must write them only while idle, the block does not enforce it.
// ---------------------------------------------------------------------------
module fsk_uart_frame_modulator #(
    parameter int TABLE_SIZE = fsk_pkg::TABLE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] char_value
    input  wire logic        s_axis_tuser,    // [0] opcode
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,    // [11:0] sample, [15:12] zero
    output logic             m_axis_tlast,    // frame_done
    // register writes
    input  wire logic                              i_cfg_we,
    input  wire logic [fsk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fsk_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IW = fsk_pkg::IDX_W;
    localparam int AW = fsk_pkg::ACC_W;
    localparam int CW = fsk_pkg::CNT_W;
    localparam int PW = fsk_pkg::PTR_W;
    localparam logic [IW:0]   TS_X   = (IW+1)'(TABLE_SIZE);
    localparam logic [CW-1:0] TS_CNT = CW'(TABLE_SIZE);
    localparam logic [PW:0]   FL_X   = (PW+1)'(fsk_pkg::FRAME_LEN);
    localparam logic [AW-IW:0] TS_ACC = (AW-IW+1)'(TABLE_SIZE);

    // configuration registers
    logic [fsk_pkg::STEP_W-1:0] r_phase_step;
    logic [fsk_pkg::SPAN_W-1:0] r_first_span;
    logic [fsk_pkg::SPAN_W-1:0] r_last_span;

    // modulator state
    logic [fsk_pkg::FRAME_LEN-1:0] r_frame;
    logic [PW-1:0] r_bit_ptr,    n_bit_ptr;
    logic          r_busy,       n_busy;
    logic [CW-1:0] r_tick_cnt,   n_tick_cnt;
    logic          r_span_phase, n_span_phase;
    logic [IW-1:0] r_table_idx,  n_table_idx;
    logic [AW-1:0] r_phase_acc,  n_phase_acc;

    // output register
    logic                          r_out_valid;
    logic [fsk_pkg::SAMPLE_W-1:0]  r_sample;
    logic                          r_done;

    logic                      w_in_fire;
    logic                      w_tick_fire;
    logic                      w_load_fire;
    logic                      w_bit;
    logic [IW-1:0]             w_rom_idx;
    logic [fsk_pkg::SAMPLE_W-1:0] w_rom_sample;
    logic                      w_done;
    logic [AW-1:0]             w_acc_cur;
    logic [AW:0]               w_acc_sum;
    logic [AW-1:0]             w_acc_next;
    logic [IW:0]               w_idx_inc;
    logic [CW-1:0]             w_cnt_inc;
    logic [PW:0]               w_ptr_inc;
    logic [fsk_pkg::FRAME_LEN-1:0] w_frame_new;

    // handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_tick_fire   = w_in_fire && (s_axis_tuser == fsk_pkg::OP_TICK);
    assign w_load_fire   = w_in_fire && (s_axis_tuser == fsk_pkg::OP_LOAD);

    // frame from character: start, data msb first, odd parity, stop
    always_comb begin
        w_frame_new[0] = 1'b0;
        for (int k = 0; k < 8; k++) begin
            w_frame_new[1 + k] = s_axis_tdata[7 - k];
        end
        w_frame_new[fsk_pkg::FRAME_LEN-2] = ~(^s_axis_tdata[6:0]);
        w_frame_new[fsk_pkg::FRAME_LEN-1] = 1'b1;
    end

    // current line level, idle is mark
    assign w_bit = r_busy ? r_frame[r_bit_ptr] : 1'b1;

    // accumulator reload on the first tick of a space bit
    assign w_acc_cur  = (r_tick_cnt == '0 && !r_span_phase) ?
                        {r_table_idx, 8'd0} : r_phase_acc;
    assign w_acc_sum  = {1'b0, w_acc_cur} + (AW+1)'(r_phase_step);
    assign w_acc_next = (w_acc_sum[AW:8] >= TS_ACC) ? '0 : w_acc_sum[AW-1:0];

    assign w_idx_inc = {1'b0, r_table_idx} + 1'b1;
    assign w_cnt_inc = r_tick_cnt + 1'b1;
    assign w_ptr_inc = {1'b0, r_bit_ptr} + 1'b1;

    assign w_rom_idx = w_bit ? r_table_idx : w_acc_cur[AW-1:8];

    fsk_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .i_index  (w_rom_idx),
        .o_sample (w_rom_sample)
    );

    // next state for one tick or load
    always_comb begin
        n_bit_ptr    = r_bit_ptr;
        n_busy       = r_busy;
        n_tick_cnt   = r_tick_cnt;
        n_span_phase = r_span_phase;
        n_table_idx  = r_table_idx;
        n_phase_acc  = r_phase_acc;
        w_done       = 1'b0;
        if (w_load_fire) begin
            n_busy       = 1'b1;
            n_bit_ptr    = '0;
            n_tick_cnt   = '0;
            n_span_phase = 1'b0;
        end else if (w_tick_fire) begin
            n_tick_cnt = w_cnt_inc;
            if (w_bit) begin
                // mark tone
                n_table_idx = (w_idx_inc >= TS_X) ? '0 : w_idx_inc[IW-1:0];
                if (w_cnt_inc == TS_CNT) begin
                    n_tick_cnt = '0;
                    if (r_busy) begin
                        if (w_ptr_inc >= FL_X) begin
                            n_bit_ptr = '0;
                            n_busy    = 1'b0;
                            w_done    = 1'b1;
                        end else begin
                            n_bit_ptr = w_ptr_inc[PW-1:0];
                        end
                    end
                end
            end else begin
                // space tone
                n_phase_acc = w_acc_next;
                if (!r_span_phase) begin
                    if (w_cnt_inc == r_first_span) begin
                        n_tick_cnt   = '0;
                        n_span_phase = 1'b1;
                    end
                end else if (w_cnt_inc == r_last_span) begin
                    n_tick_cnt   = '0;
                    n_span_phase = 1'b0;
                    n_table_idx  = w_acc_next[AW-1:8];
                    if (w_ptr_inc >= FL_X) begin
                        n_bit_ptr = '0;
                        n_busy    = 1'b0;
                        w_done    = 1'b1;
                    end else begin
                        n_bit_ptr = w_ptr_inc[PW-1:0];
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ptr    <= '0;
            r_busy       <= 1'b0;
            r_tick_cnt   <= '0;
            r_span_phase <= 1'b0;
            r_table_idx  <= '0;
            r_phase_acc  <= '0;
        end else begin
            r_bit_ptr    <= n_bit_ptr;
            r_busy       <= n_busy;
            r_tick_cnt   <= n_tick_cnt;
            r_span_phase <= n_span_phase;
            r_table_idx  <= n_table_idx;
            r_phase_acc  <= n_phase_acc;
        end
    end

    // frame store, written by a load only
    always_ff @(posedge i_clk) begin
        if (w_load_fire) begin
            r_frame <= w_frame_new;
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= fsk_pkg::PHASE_STEP_RST;
            r_first_span <= fsk_pkg::FIRST_SPAN_RST;
            r_last_span  <= fsk_pkg::LAST_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fsk_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                fsk_pkg::CFG_FIRST_SPAN: r_first_span <= i_cfg_data[fsk_pkg::SPAN_W-1:0];
                fsk_pkg::CFG_LAST_SPAN:  r_last_span  <= i_cfg_data[fsk_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_sample <= w_rom_sample;
            r_done   <= w_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_sample};
    assign m_axis_tlast  = r_done;

    // checks
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_fire && !r_busy) |=> !m_axis_tlast)
        else $error("frame end flagged on an idle tick");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_fire && w_done) |=> !r_busy)
        else $error("still busy after frame end");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_fire |=> (r_busy && r_bit_ptr == '0 && r_tick_cnt == '0 && !r_span_phase))
        else $error("load did not restart the frame");

    a_idle_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_bit_ptr == '0))
        else $error("bit pointer moved while idle");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_table_idx} < TS_X) && (r_phase_acc[AW-1:8] < TS_ACC[AW-IW-1:0]))
        else $error("table index out of range");

endmodule
`default_nettype wire
